// ===== rtl/ffsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared sizes, codes and types of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int MAX_SEGS = 16;
   localparam int IDX_W    = $clog2(MAX_SEGS);
   localparam int CNT_W    = $clog2(MAX_SEGS + 1);
   localparam int ADDR_W   = 16;
   localparam int JOB_W    = 16;

   localparam logic [ADDR_W-1:0] ARENA_BASE_RESET = 16'd5;
   localparam logic [ADDR_W-1:0] ARENA_SIZE_RESET = 16'd507;

   localparam logic [1:0] CMD_INIT   = 2'd0;
   localparam logic [1:0] CMD_ALLOC  = 2'd1;
   localparam logic [1:0] CMD_FREE   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] STS_DONE     = 2'd0;
   localparam logic [1:0] STS_NO_FIT   = 2'd1;
   localparam logic [1:0] STS_FULL     = 2'd2;
   localparam logic [1:0] STS_NO_JOB   = 2'd3;

   localparam logic CSR_ARENA_BASE = 1'b0;
   localparam logic CSR_ARENA_SIZE = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic              busy;
      logic [JOB_W-1:0]  owner;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       init;
      logic       scan_next;
      logic       capture;
      logic       free_clear;
      logic       shift_begin;
      logic       shift_move;
      logic       write_rem;
      logic       write_hit;
      logic       result;
      logic [1:0] result_status;
      logic       grant;
   } dp_cmd_type;

   typedef struct packed {
      logic fit;
      logic owned;
      logic last;
      logic full;
      logic shift_done;
      logic found;
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== rtl/first_fit_segment_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// Address-ordered segment table with first-fit allocate and per-job free.
// ----------------------------------------------------------------------------
//   Channel    Ports                                         Handshake
//   request    req_command, req_length, req_job_id           start & !busy
//   response   rsp_status, rsp_grant_address                 rsp_valid, one cycle
//   registers  csr_index, csr_wdata                          csr_we
//
// Init and unused commands answer in the cycle after acceptance.
// Allocate scans entries up to the first fit, then shifts each entry behind
// it up one slot, writes the remainder and marks the hit entry busy.
// Free scans every valid entry. The table holds up to 16 segments.
// Reset leaves one free segment at base 5 with length 507.
// The response is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
   import ffsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_command,
   input  wire logic [ADDR_W-1:0] req_length,
   input  wire logic [JOB_W-1:0]  req_job_id,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [ADDR_W-1:0]      rsp_grant_address,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [ADDR_W-1:0] csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       start_ok;

   assign start_ok = start && !busy;

   ffsa_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .start       (start_ok),
      .req_command (req_command),
      .sts         (sts),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   ffsa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_length        (req_length),
      .req_job_id        (req_job_id),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_grant_address (rsp_grant_address)
   );

endmodule
`default_nettype wire

// ===== rtl/ffsa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_datapath
// Segment table, scan and shift pointers, request and result registers.
// ----------------------------------------------------------------------------
module ffsa_datapath
   import ffsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [ADDR_W-1:0] csr_wdata,
   input  wire logic [ADDR_W-1:0] req_length,
   input  wire logic [JOB_W-1:0]  req_job_id,
   input  wire dp_cmd_type        cmd,
   output dp_sts_type             sts,
   output logic [1:0]             rsp_status,
   output logic [ADDR_W-1:0]      rsp_grant_address
);

   entry_type          table_ff [MAX_SEGS];
   logic [ADDR_W-1:0]  base_ff;
   logic [ADDR_W-1:0]  size_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   wp_ff;
   logic [IDX_W-1:0]   hit_ff;
   logic [ADDR_W-1:0]  hit_start_ff;
   logic [ADDR_W-1:0]  hit_length_ff;
   logic [ADDR_W-1:0]  len_ff;
   logic [JOB_W-1:0]   job_ff;
   logic               found_ff;
   logic [1:0]         status_ff;
   logic [ADDR_W-1:0]  grant_ff;

   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_entry;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   assign rd_addr  = cmd.shift_move ? wp_ff - IDX_W'(1) : idx_ff;
   assign rd_entry = table_ff[rd_addr];

   assign sts.fit        = !rd_entry.busy && (len_ff < rd_entry.length);
   assign sts.owned      = rd_entry.busy && (rd_entry.owner == job_ff);
   assign sts.last       = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign sts.full       = count_ff == CNT_W'(MAX_SEGS);
   assign sts.shift_done = (CNT_W'(hit_ff) + CNT_W'(1)) == CNT_W'(wp_ff);
   assign sts.found      = found_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_entry;
      if (cmd.init) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = '{start: base_ff, length: size_ff, busy: 1'b0, owner: '0};
      end else if (cmd.shift_move) begin
         wr_en   = 1'b1;
         wr_addr = wp_ff;
         wr_data = rd_entry;
      end else if (cmd.write_rem) begin
         wr_en   = 1'b1;
         wr_addr = wp_ff;
         wr_data = '{start: hit_start_ff + len_ff, length: hit_length_ff - len_ff,
                     busy: 1'b0, owner: '0};
      end else if (cmd.write_hit) begin
         wr_en   = 1'b1;
         wr_addr = hit_ff;
         wr_data = '{start: hit_start_ff, length: len_ff, busy: 1'b1, owner: job_ff};
      end else if (cmd.free_clear) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = '{start: rd_entry.start, length: rd_entry.length,
                     busy: 1'b0, owner: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff[0] <= '{start: ARENA_BASE_RESET, length: ARENA_SIZE_RESET,
                          busy: 1'b0, owner: '0};
      end else if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= ARENA_BASE_RESET;
         size_ff  <= ARENA_SIZE_RESET;
         count_ff <= CNT_W'(1);
         idx_ff   <= '0;
         wp_ff    <= '0;
         hit_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ARENA_BASE: base_ff <= csr_wdata;
               CSR_ARENA_SIZE: size_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan_next) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.free_clear) begin
            found_ff <= 1'b1;
         end
         if (cmd.init) begin
            count_ff <= CNT_W'(1);
         end else if (cmd.write_hit) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.capture) begin
            hit_ff <= idx_ff;
         end
         if (cmd.shift_begin) begin
            wp_ff <= IDX_W'(count_ff);
         end else if (cmd.shift_move) begin
            wp_ff <= wp_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff <= req_length;
         job_ff <= req_job_id;
      end
      if (cmd.capture) begin
         hit_start_ff  <= rd_entry.start;
         hit_length_ff <= rd_entry.length;
      end
      if (cmd.result) begin
         status_ff <= cmd.result_status;
         grant_ff  <= cmd.grant ? hit_start_ff : '0;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_grant_address = grant_ff;

endmodule
`default_nettype wire

// ===== rtl/ffsa_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_controller
// Sequences init, allocate and free items over the segment table.
// ----------------------------------------------------------------------------
module ffsa_controller
   import ffsa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] req_command,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_SCAN,
      ST_SHIFT,
      ST_MARK,
      ST_FREE_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_command)
                  CMD_ALLOC: begin
                     state_in = ST_ALLOC_SCAN;
                     busy_in  = 1'b1;
                  end
                  CMD_FREE: begin
                     state_in = ST_FREE_SCAN;
                     busy_in  = 1'b1;
                  end
                  CMD_INIT: begin
                     cmd.init     = 1'b1;
                     cmd.result   = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     cmd.result   = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ALLOC_SCAN: begin
            if (sts.fit) begin
               cmd.capture = 1'b1;
               if (sts.full) begin
                  cmd.result        = 1'b1;
                  cmd.result_status = STS_FULL;
                  rsp_valid_in      = 1'b1;
                  busy_in           = 1'b0;
                  state_in          = ST_IDLE;
               end else begin
                  cmd.shift_begin = 1'b1;
                  state_in        = ST_SHIFT;
               end
            end else if (sts.last) begin
               cmd.result        = 1'b1;
               cmd.result_status = STS_NO_FIT;
               rsp_valid_in      = 1'b1;
               busy_in           = 1'b0;
               state_in          = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (sts.shift_done) begin
               cmd.write_rem = 1'b1;
               state_in      = ST_MARK;
            end else begin
               cmd.shift_move = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.write_hit     = 1'b1;
            cmd.result        = 1'b1;
            cmd.result_status = STS_DONE;
            cmd.grant         = 1'b1;
            rsp_valid_in      = 1'b1;
            busy_in           = 1'b0;
            state_in          = ST_IDLE;
         end
         ST_FREE_SCAN: begin
            cmd.free_clear = sts.owned;
            if (sts.last) begin
               cmd.result        = 1'b1;
               cmd.result_status = (sts.found || sts.owned) ? STS_DONE : STS_NO_JOB;
               rsp_valid_in      = 1'b1;
               busy_in           = 1'b0;
               state_in          = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/ffsa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the allocator's command and response behavior.
// ----------------------------------------------------------------------------
module ffsa_checker
   import ffsa_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic [1:0]        req_command,
   input wire logic              rsp_valid,
   input wire logic [1:0]        rsp_status,
   input wire logic [ADDR_W-1:0] rsp_grant_address
);

   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_DONE |-> rsp_grant_address == '0)
      else $error("Grant address is nonzero on a failed item.");

   a_quick_commands: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_INIT || req_command == CMD_UNUSED)
      |=> rsp_valid && !busy && rsp_status == STS_DONE)
      else $error("Init or unused command did not answer in one cycle.");

   a_long_commands_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_ALLOC || req_command == CMD_FREE)
      |=> busy && !rsp_valid)
      else $error("Allocate or free did not enter the busy phase.");

   a_end_has_response: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("Busy phase ended without a response.");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_grant_address (rsp_grant_address)
);
`default_nettype wire
